>>> rtl/b2da_pkg.sv
`timescale 1ns / 1ps
// constants shared by the binary to decimal ascii unit
// no dependencies

package b2da_pkg;

   // width of one packed decimal digit
   localparam int unsigned DIGIT_W = 4;

   // ascii code of character zero, at the width of the digit_char field
   localparam logic [5:0] ASCII_ZERO = 6'd48;

   // width of the digit_char result field
   localparam int unsigned CHAR_W = 6;

   // largest digit that is left alone before a doubling step
   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd4;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

   // log10(2) scaled by 4096, for the digit count of a binary width
   localparam int unsigned LOG2_10_NUM   = 1233;
   localparam int unsigned LOG2_10_SCALE = 4096;

endpackage

>>> rtl/binary_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// binary to decimal ascii converter, bit-serial double dabble
// depends on b2da_pkg

// One request carries an unsigned VALUE_BITS-bit number in the low bits of
// req_tdata; the upper bits are ignored. The unit answers with one response per
// decimal digit, as an ascii character, most significant digit first, leading
// zeros dropped, a zero value giving the single character '0'. rsp_tlast marks
// the least significant digit. Conversion is double dabble, one bit per cycle:
// the number is shifted bit by bit into a packed decimal shift register, then
// each decimal digit position (DIGITS of them, 20 at 64 bits) is walked in turn
// from the top, skipping leading zeros or loading the result register. The walk
// waits while the result register holds a digit not yet taken. A request is
// taken only in the idle state, and one request is in work at a time; the next
// request is taken as soon as the last digit sits in the result register, so
// its conversion overlaps the final handshake.

module binary_to_decimal_ascii_unit #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // value [63:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // digit_char [5:0], zero fill [7:6]
   output logic        rsp_tlast     // last
);

   // decimal digits needed for the widest value
   localparam int unsigned DIGITS =
      (VALUE_BITS * b2da_pkg::LOG2_10_NUM) / b2da_pkg::LOG2_10_SCALE + 1;
   localparam int unsigned BCD_W  = DIGITS * b2da_pkg::DIGIT_W;
   localparam int unsigned CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int unsigned REM_W  = $clog2(DIGITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [VALUE_BITS-1:0]     bin_ff, bin_in;       // binary bits still to shift in
   logic [BCD_W-1:0]          bcd_ff, bcd_in;       // packed decimal digits
   logic [CNT_W-1:0]          bit_cnt_ff, bit_cnt_in;
   logic [REM_W-1:0]          remain_ff, remain_in; // digit positions left to walk
   logic                      started_ff, started_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [b2da_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]          bcd_adj;
   logic [b2da_pkg::DIGIT_W-1:0] top_digit;
   logic                      out_free;
   logic                      req_take;

   // add three to every digit above four before the doubling shift
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] > b2da_pkg::DABBLE_LIMIT) begin
            bcd_adj[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
               bcd_ff[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + b2da_pkg::DABBLE_ADD;
         end else begin
            bcd_adj[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
               bcd_ff[d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
         end
      end
   end

   assign top_digit  = bcd_ff[BCD_W-1 -: b2da_pkg::DIGIT_W];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      remain_in    = remain_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      // result register empties when taken
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               bin_in     = req_tdata[VALUE_BITS-1:0];
               bcd_in     = '0;
               bit_cnt_in = CNT_W'(VALUE_BITS - 1);
               started_in = 1'b0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // one binary bit enters the decimal register per cycle
            bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_BITS-1]};
            bin_in     = bin_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               remain_in = REM_W'(DIGITS);
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               bcd_in    = {bcd_ff[BCD_W-b2da_pkg::DIGIT_W-1:0], {b2da_pkg::DIGIT_W{1'b0}}};
               remain_in = remain_ff - 1'b1;
               if (!started_ff && top_digit == '0 && remain_ff != REM_W'(1)) begin
                  // leading zero, skip it
                  rsp_valid_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
                  rsp_last_in  = (remain_ff == REM_W'(1));
                  started_in   = 1'b1;
               end
               if (remain_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      remain_ff   <= remain_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   // every character shown is a decimal digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:0] >= 6'd48 && rsp_tdata[5:0] <= 6'd57))
      else $error("response character is not a decimal digit");

   // conversion only ends by moving on to emission
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONVERT |=> (state_ff == ST_CONVERT || state_ff == ST_EMIT))
      else $error("conversion left without emission");

   // once the first digit is out, no later position is skipped
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && started_ff && out_free) |=> rsp_tvalid)
      else $error("inner zero digit was skipped");

   // a new request is never taken while digits are still being walked
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !req_tready)
      else $error("request accepted during emission");

endmodule

>>> tb/binary_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the binary to decimal ascii unit: directed and random values
// checked digit by digit against a predicted character stream, under varied back-pressure
// depends on b2da_pkg and binary_to_decimal_ascii_unit

module binary_to_decimal_ascii_unit_tb;

   localparam int unsigned VALUE_BITS  = 64;
   localparam int unsigned RANDOM_REQS = 100;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned TAIL_CYCLES = 150;

   // one expected response: ascii digit and end-of-number flag
   typedef struct packed {
      logic [b2da_pkg::CHAR_W-1:0] digit_char;
      logic                        last;
   } digit_resp_type;

   // expected digit stream, filled on request acceptance, drained on response
   class digit_ledger_type;
      digit_resp_type awaited[$];
      int             errors;

      function new();
         errors = 0;
      endfunction

      // split the value into decimal digits, most significant first
      function void note_value(logic [63:0] value);
         logic [63:0]                  n;
         logic [b2da_pkg::DIGIT_W-1:0] digits[$];
         digit_resp_type               d;
         n = (VALUE_BITS >= 64) ? value : (value & ((64'd1 << VALUE_BITS) - 64'd1));
         do begin
            digits.push_back(b2da_pkg::DIGIT_W'(n % 64'd10));
            n = n / 64'd10;
         end while (n != 64'd0);
         for (int i = digits.size() - 1; i >= 0; i--) begin
            d.digit_char = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digits[i]);
            d.last       = (i == 0);
            awaited.push_back(d);
         end
      endfunction

      function void check_digit(logic [b2da_pkg::CHAR_W-1:0] digit_char, logic last);
         digit_resp_type exp_d;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected response digit_char %0d last %0b",
                     $time, digit_char, last);
            errors++;
         end else begin
            exp_d = awaited.pop_front();
            if (digit_char !== exp_d.digit_char) begin
               $display("%0t: digit_char mismatch, expected %0d actual %0d",
                        $time, exp_d.digit_char, digit_char);
               errors++;
            end
            if (last !== exp_d.last) begin
               $display("%0t: last mismatch, expected %0b actual %0b",
                        $time, exp_d.last, last);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;     // value [63:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // digit_char [5:0], zero fill [7:6]
   logic        rsp_tlast;           // last

   // idling percentages for the current phase
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count    = 0;

   digit_ledger_type ledger = new();

   binary_to_decimal_ascii_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver side: random back-pressure at the phase's stall rate
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // response monitor, sampling pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.check_digit(rsp_tdata[b2da_pkg::CHAR_W-1:0], rsp_tlast);
      end
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d digits still awaited", $time, ledger.awaited.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // one request: optional idle gap, then hold valid until the handshake
   task automatic send_value(input logic [63:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      ledger.note_value(value);
   endtask

   // drop valid and let every awaited digit come out
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] power_of_ten(int unsigned k);
      logic [63:0] p;
      p = 64'd1;
      for (int unsigned i = 0; i < k; i++) p = p * 64'd10;
      return p;
   endfunction

   // random value with a spread of digit counts, weighted around decimal edges
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      int unsigned pick;
      v    = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         return v;
      end else if (pick < 8) begin
         return v >> $urandom_range(0, 63);
      end else if (pick == 8) begin
         return power_of_ten($urandom_range(0, 19));
      end else begin
         return power_of_ten($urandom_range(1, 19)) - 64'd1;
      end
   endfunction

   initial begin
      logic [63:0] directed_values[$];

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, single digits, decimal edges, widest values, bit patterns
      directed_values = '{
         64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd12345,
         64'd4294967295, 64'd4294967296, 64'd1000000007,
         64'd999999999999999999, 64'd1000000000000000000,
         64'd9999999999999999999, 64'd10000000000000000000,
         64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
         64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
         64'h0123_4567_89AB_CDEF, 64'd0
      };
      foreach (directed_values[i]) send_value(directed_values[i]);
      drain_responses();

      // random phases: free flow, sender gaps, receiver stalls, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 54;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 54;
            end
            default: begin
               send_idle_pct  = 31;
               recv_stall_pct = 31;
            end
         endcase
         for (int n = 0; n < RANDOM_REQS / 4; n++) send_value(random_value());
         drain_responses();
      end

      // catch any stray digit after the last expected one
      repeat (TAIL_CYCLES) @(posedge clock);
      if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/b2da_pkg.sv
rtl/binary_to_decimal_ascii_unit.sv
tb/binary_to_decimal_ascii_unit_tb.sv
